// ----- hw/rtl/sdrs_pkg.sv -----
// Shared widths, codes, defaults and controller/datapath types for the SCAN disk scheduler.
package sdrs_pkg;

    localparam int CYL_W    = 10;
    localparam int TAG_W    = 16;
    localparam int CFG_W    = 16;
    localparam int TIME_W   = 26;
    localparam int TRAVEL_W = 32;
    localparam int QCNT_W   = 5;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_NUM_CYLINDERS = 1024;
    localparam int DEF_HOME_CYL      = 100;

    localparam logic [CFG_W-1:0] RST_OVERHEAD_US = 16'd3333;
    localparam logic [CFG_W-1:0] RST_SEEK_US     = 16'd15600;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK     = 1'b1;

    localparam logic ACT_ENQUEUE  = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    localparam logic [STAT_W-1:0] STAT_ACCEPTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SERVED   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [CYL_W-1:0] cyl;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic enq;
        logic disp_empty;
        logic scan_clr;
        logic scan_rd;
        logic flip;
        logic shift_init;
        logic shift_rd;
        logic mul;
        logic serve;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic found;
        logic shift_none;
        logic shift_last;
    } t_dp_sts;

endpackage

// ----- hw/rtl/sdrs_dp.sv -----
// Datapath of the SCAN disk scheduler: entry memory, scan compare, shift, arithmetic, results.
module sdrs_dp
    import sdrs_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int NUM_CYLINDERS = DEF_NUM_CYLINDERS,
    parameter int HOME_CYL      = DEF_HOME_CYL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic [CYL_W-1:0]      i_cylinder,
    input  logic [TAG_W-1:0]      i_req_tag,
    output logic                  o_strobe,
    output logic [STAT_W-1:0]     o_status,
    output logic [TAG_W-1:0]      o_served_tag,
    output logic [CYL_W-1:0]      o_served_cylinder,
    output logic [CYL_W-1:0]      o_seek_distance,
    output logic [TIME_W-1:0]     o_service_time_us,
    output logic                  o_scan_outward,
    output logic [TRAVEL_W-1:0]   o_head_travel_total,
    output logic [QCNT_W-1:0]     o_queue_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [16:0] MAX_CYL = 17'(NUM_CYLINDERS - 1);

    t_entry                r_mem [QUEUE_DEPTH];
    t_entry                r_rd_data;
    logic [AW-1:0]         r_rd_idx;
    logic [AW-1:0]         r_wr_idx;
    logic [AW-1:0]         r_cmp_idx;
    logic                  r_rd_vld;
    logic                  r_sh_vld;

    logic [CYL_W-1:0]      r_in_cyl;
    logic [TAG_W-1:0]      r_in_tag;
    logic [CW-1:0]         r_count;
    logic [CYL_W-1:0]      r_head;
    logic                  r_outward;
    logic [TRAVEL_W-1:0]   r_travel;
    logic [CFG_W-1:0]      r_overhead;
    logic [CFG_W-1:0]      r_seek;

    logic                  r_force;
    logic                  r_found;
    logic [AW-1:0]         r_best_idx;
    logic [CYL_W-1:0]      r_best_dist;
    t_entry                r_best_entry;
    logic [TIME_W-1:0]     r_prod;

    logic                  r_strobe;
    logic [STAT_W-1:0]     r_status;
    logic [TAG_W-1:0]      r_served_tag;
    logic [CYL_W-1:0]      r_served_cyl;
    logic [CYL_W-1:0]      r_seek_dist;
    logic [TIME_W-1:0]     r_stime;
    logic [QCNT_W-1:0]     r_qcount;
    logic                  r_res_outward;
    logic [TRAVEL_W-1:0]   r_res_travel;

    logic                  full;
    logic [CW-1:0]         last_idx;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    t_entry                wr_data;
    logic [CYL_W-1:0]      cyl_sat;
    logic                  ge_head;
    logic [CYL_W-1:0]      cmp_dist;
    logic                  cand;
    logic                  better;
    logic [TRAVEL_W:0]     travel_sum;

    assign full     = (r_count == CW'(QUEUE_DEPTH));
    assign last_idx = r_count - CW'(1);

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.scan_last  = (CW'(r_rd_idx) == last_idx);
    assign o_sts.found      = r_found;
    assign o_sts.shift_none = (CW'(r_best_idx) == last_idx);
    assign o_sts.shift_last = (CW'(r_rd_idx) == last_idx);

    assign cyl_sat = ({7'd0, i_cylinder} > MAX_CYL) ? CYL_W'(MAX_CYL) : i_cylinder;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_idx;
        wr_data = r_rd_data;
        if (r_sh_vld) begin
            wr_en = 1'b1;
        end else if (i_cmd.enq && !full) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = '{cyl: r_in_cyl, tag: r_in_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    assign ge_head  = (r_rd_data.cyl >= r_head);
    assign cmp_dist = ge_head ? (r_rd_data.cyl - r_head) : (r_head - r_rd_data.cyl);
    assign cand     = r_force || (r_outward ? ge_head : !ge_head);
    assign better   = cand && (!r_found || (cmp_dist < r_best_dist));

    assign travel_sum = {1'b0, r_travel} + (TRAVEL_W + 1)'(r_best_dist);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_cyl <= cyl_sat;
            r_in_tag <= i_req_tag;
        end
        r_rd_vld <= i_cmd.scan_rd;
        r_sh_vld <= i_cmd.shift_rd;
        if (i_cmd.scan_clr) begin
            r_rd_idx <= '0;
            r_force  <= (r_count == CW'(1));
        end else if (i_cmd.shift_init) begin
            r_rd_idx <= r_best_idx + AW'(1);
            r_wr_idx <= r_best_idx;
        end else if (i_cmd.scan_rd || i_cmd.shift_rd) begin
            r_rd_idx <= r_rd_idx + AW'(1);
        end
        if (i_cmd.scan_rd) begin
            r_cmp_idx <= r_rd_idx;
        end
        if (r_sh_vld) begin
            r_wr_idx <= r_wr_idx + AW'(1);
        end
        if (r_rd_vld && better) begin
            r_best_idx   <= r_cmp_idx;
            r_best_dist  <= cmp_dist;
            r_best_entry <= r_rd_data;
        end
        if (i_cmd.mul) begin
            r_prod <= TIME_W'(r_best_dist) * TIME_W'(r_seek);
        end
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_found <= 1'b0;
        end else if (r_rd_vld && better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_head     <= CYL_W'(HOME_CYL);
            r_outward  <= 1'b1;
            r_travel   <= '0;
            r_overhead <= RST_OVERHEAD_US;
            r_seek     <= RST_SEEK_US;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OVERHEAD: r_overhead <= i_cfg_data;
                    CFG_SEEK:     r_seek     <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_cmd.enq && !full) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.flip) begin
                r_outward <= !r_outward;
            end
            if (i_cmd.mul) begin
                r_count  <= r_count - CW'(1);
                r_head   <= r_best_entry.cyl;
                r_travel <= travel_sum[TRAVEL_W] ? '1 : travel_sum[TRAVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq || i_cmd.disp_empty || i_cmd.serve) begin
            r_served_tag  <= '0;
            r_served_cyl  <= '0;
            r_seek_dist   <= '0;
            r_stime       <= '0;
            r_res_outward <= r_outward;
            r_res_travel  <= r_travel;
            r_qcount      <= QCNT_W'(r_count);
            if (i_cmd.enq) begin
                r_status <= full ? STAT_REJECTED : STAT_ACCEPTED;
                if (!full) begin
                    r_qcount <= QCNT_W'(r_count + CW'(1));
                end
            end else if (i_cmd.disp_empty) begin
                r_status <= STAT_EMPTY;
            end else begin
                r_status     <= STAT_SERVED;
                r_served_tag <= r_best_entry.tag;
                r_served_cyl <= r_best_entry.cyl;
                r_seek_dist  <= r_best_dist;
                r_stime      <= TIME_W'(r_overhead) + r_prod;
            end
        end
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.enq || i_cmd.disp_empty || i_cmd.serve;
        end
    end

    assign o_strobe            = r_strobe;
    assign o_status            = r_status;
    assign o_served_tag        = r_served_tag;
    assign o_served_cylinder   = r_served_cyl;
    assign o_seek_distance     = r_seek_dist;
    assign o_service_time_us   = r_stime;
    assign o_scan_outward      = r_res_outward;
    assign o_head_travel_total = r_res_travel;
    assign o_queue_count       = r_qcount;

endmodule

// ----- hw/rtl/sdrs_ctrl.sv -----
// Controller state machine of the SCAN disk scheduler.
module sdrs_ctrl
    import sdrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_action,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_DISP,
        S_SCAN,
        S_SCAN_END,
        S_CHECK,
        S_SHIFT_INIT,
        S_SHIFT,
        S_SHIFT_END,
        S_MUL,
        S_SERVE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_flipped;
    logic   n_flipped;
    logic   accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_flipped = r_flipped;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = accept;
                if (accept) begin
                    n_state = (i_action == ACT_DISPATCH) ? S_DISP : S_ENQ;
                end
            end
            S_ENQ: begin
                o_cmd.enq = 1'b1;
                n_state   = S_IDLE;
            end
            S_DISP: begin
                n_flipped = 1'b0;
                if (i_sts.empty) begin
                    o_cmd.disp_empty = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.found || r_flipped) begin
                    n_state = S_SHIFT_INIT;
                end else begin
                    o_cmd.flip     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_flipped      = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SHIFT_INIT: begin
                o_cmd.shift_init = 1'b1;
                n_state          = i_sts.shift_none ? S_MUL : S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift_rd = 1'b1;
                if (i_sts.shift_last) begin
                    n_state = S_SHIFT_END;
                end
            end
            S_SHIFT_END: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SERVE;
            end
            S_SERVE: begin
                o_cmd.serve = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_flipped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_flipped <= n_flipped;
        end
    end

endmodule

// ----- hw/rtl/scan_disk_request_scheduler.sv -----
// Top level of the SCAN (elevator) disk request scheduler.
//
// Channel   Direction  Handshake                   Payload
// item      in         start high, busy low        i_action, i_cylinder, i_req_tag
// result    out        o_strobe, one cycle only    o_status ... o_queue_count
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// An enqueue item, or a dispatch to an empty queue, goes through its S_ENQ or S_DISP state
// and then raises its registered result strobe. A dispatch scans the queued entries once,
// or twice after a reversal, then shifts the younger entries down; every step goes
// through the single read port of the entry memory.
// Reset is synchronous and active low; the queue comes out of reset empty.
// Results cannot be held off, and busy stays high until the result is issued.
module scan_disk_request_scheduler
    import sdrs_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int NUM_CYLINDERS = DEF_NUM_CYLINDERS,
    parameter int HOME_CYL      = DEF_HOME_CYL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [CYL_W-1:0]      i_cylinder,
    input  logic [TAG_W-1:0]      i_req_tag,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_strobe,
    output logic [STAT_W-1:0]     o_status,
    output logic [TAG_W-1:0]      o_served_tag,
    output logic [CYL_W-1:0]      o_served_cylinder,
    output logic [CYL_W-1:0]      o_seek_distance,
    output logic [TIME_W-1:0]     o_service_time_us,
    output logic                  o_scan_outward,
    output logic [TRAVEL_W-1:0]   o_head_travel_total,
    output logic [QCNT_W-1:0]     o_queue_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sdrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    sdrs_dp #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .NUM_CYLINDERS (NUM_CYLINDERS),
        .HOME_CYL      (HOME_CYL)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_cylinder          (i_cylinder),
        .i_req_tag           (i_req_tag),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_served_tag        (o_served_tag),
        .o_served_cylinder   (o_served_cylinder),
        .o_seek_distance     (o_seek_distance),
        .o_service_time_us   (o_service_time_us),
        .o_scan_outward      (o_scan_outward),
        .o_head_travel_total (o_head_travel_total),
        .o_queue_count       (o_queue_count)
    );

endmodule

// ----- hw/rtl/sdrs_checker.sv -----
// Port-level assertions for the SCAN disk scheduler and their binding to the top level.
module sdrs_checker
    import sdrs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_strobe,
    input logic [STAT_W-1:0]     o_status,
    input logic [TAG_W-1:0]      o_served_tag,
    input logic [CYL_W-1:0]      o_served_cylinder,
    input logic [CYL_W-1:0]      o_seek_distance,
    input logic [TIME_W-1:0]     o_service_time_us
);

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without an item in progress");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe lasted more than one cycle");

    a_no_service_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != STAT_SERVED)) |->
            (o_served_tag == '0) && (o_served_cylinder == '0) &&
            (o_seek_distance == '0) && (o_service_time_us == '0))
        else $error("service fields not cleared on a non-service result");

endmodule

bind scan_disk_request_scheduler sdrs_checker u_sdrs_checker (.*);
